/* design/rms_pkg.sv */
// Shared types, constants and helper functions of the rotary mode selector.
// Has no dependencies. Every other file of the block depends on it.
package rms_pkg;

  // Default number of modes: auto, closed, breeze, turbo.
  localparam int unsigned NumModesDef = 4;

  // Reset values of the configuration registers.
  localparam logic [15:0] DebounceRst = 16'd40;
  localparam logic [2:0]  DetentRst   = 3'd4;

  // Configuration register indexes, selected by paddr[2].
  localparam logic RegDebounce = 1'b0;
  localparam logic RegDetent   = 1'b1;

  // Item operation codes.
  localparam logic OpSample = 1'b0;
  localparam logic OpForce  = 1'b1;

  // Switch levels.
  localparam logic SwPressed  = 1'b0;
  localparam logic SwReleased = 1'b1;

  typedef enum logic [1:0] {
    DirNone,
    DirUp,
    DirDown
  } dir_e;

  typedef struct packed {
    logic        opcode;
    logic        enc_a;
    logic        enc_b;
    logic        switch_level;
    logic [31:0] now_ms;
    logic [1:0]  new_mode;
  } item_t;

  typedef struct packed {
    logic       changed;
    logic [1:0] active_mode;
    logic [1:0] pending_mode;
    logic [3:0] led_n;
  } result_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [2:0]  counts_per_detent;
  } cfg_t;

  // Quadrature decode of {previous phase, new phase}, phase = {A, B}.
  function automatic dir_e quad_dir(input logic [3:0] pair);
    dir_e dir;
    case (pair) inside
      4'b1101, 4'b0100, 4'b0010, 4'b1011: dir = DirUp;
      4'b1110, 4'b0111, 4'b0001, 4'b1000: dir = DirDown;
      default:                            dir = DirNone;
    endcase
    return dir;
  endfunction

endpackage

/* design/rms_stream_if.sv */
// Valid/ready channel interfaces for the items and results of the selector.
// Depends on rms_pkg for the payload types.
interface rms_item_if;
  logic          valid;
  logic          ready;
  rms_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rms_res_if;
  logic            valid;
  logic            ready;
  rms_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/rms_cfg_regs.sv */
// APB-style configuration registers: debounce time and counts per detent.
// Depends on rms_pkg.
module rms_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output rms_pkg::cfg_t cfg_o
);
  import rms_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[2])
        RegDebounce: cfg_d.debounce_ms       = pwdata[15:0];
        RegDetent:   cfg_d.counts_per_detent = pwdata[2:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegDebounce: prdata = {16'd0, cfg_q.debounce_ms};
      RegDetent:   prdata = {29'd0, cfg_q.counts_per_detent};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms       <= DebounceRst;
      cfg_q.counts_per_detent <= DetentRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/rms_core.sv */
// Encoder decode, detent stepping, switch debounce and mode state.
// Updates its state and produces one result for each item it is fired with.
// Depends on rms_pkg.
module rms_core #(
  parameter int unsigned NUM_MODES = rms_pkg::NumModesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  rms_pkg::item_t   item_i,
  input  rms_pkg::cfg_t    cfg_i,
  output rms_pkg::result_t res_o
);
  import rms_pkg::*;

  // At least two bits so that the two-bit mode fields always fit.
  localparam int unsigned SelW = (NUM_MODES > 4) ? $clog2(NUM_MODES) : 2;
  localparam logic [SelW:0]   NumModesExt = (SelW+1)'(NUM_MODES);
  localparam logic [SelW-1:0] ModeMax     = SelW'(NUM_MODES - 1);
  localparam logic [SelW-1:0] ModeRst     = SelW'(2);
  localparam logic [SelW:0]   LedCount    = (SelW+1)'(4);

  logic [1:0]            last_phase_q, last_phase_d;
  logic                  primed_q, primed_d;
  logic signed [3:0]     step_q, step_d;
  logic [SelW-1:0]       preview_q, preview_d;
  logic [SelW-1:0]       current_q, current_d;
  logic [SelW-1:0]       shown_q, shown_d;
  logic                  last_rd_q, last_rd_d;
  logic                  stable_q, stable_d;
  logic [31:0]           last_chg_q, last_chg_d;

  logic                  changed;
  logic [2:0]            limit;
  logic signed [3:0]     limit_s;
  logic [1:0]            phase;
  dir_e                  dir;
  logic [SelW:0]         force_ext;
  logic [SelW:0]         up_ext;
  logic [31:0]           elapsed;
  logic [SelW:0]         shown_ext;

  assign phase     = {item_i.enc_a, item_i.enc_b};
  assign dir       = quad_dir({last_phase_q, phase});
  assign limit     = (cfg_i.counts_per_detent == 3'd0) ? 3'd1 : cfg_i.counts_per_detent;
  assign limit_s   = signed'({1'b0, limit});
  assign force_ext = {(SelW-1)'(0), item_i.new_mode};

  always_comb begin
    last_phase_d = last_phase_q;
    primed_d     = primed_q;
    step_d       = step_q;
    preview_d    = preview_q;
    current_d    = current_q;
    shown_d      = shown_q;
    last_rd_d    = last_rd_q;
    stable_d     = stable_q;
    last_chg_d   = last_chg_q;
    changed      = 1'b0;
    up_ext       = '0;
    elapsed      = '0;

    if (item_i.opcode == OpForce) begin
      current_d = (force_ext >= NumModesExt) ? ModeMax : force_ext[SelW-1:0];
      preview_d = current_d;
      shown_d   = current_d;
    end else if (!primed_q) begin
      // The first sample only establishes the starting phase.
      last_phase_d = phase;
      primed_d     = 1'b1;
    end else begin
      case (dir)
        DirUp:   step_d = step_q + 4'sd1;
        DirDown: step_d = step_q - 4'sd1;
        default: step_d = step_q;
      endcase

      // A compare with >= also catches a count left above a lowered limit.
      if (step_d >= limit_s) begin
        step_d    = '0;
        up_ext    = {1'b0, preview_q} + (SelW+1)'(1);
        preview_d = (up_ext >= NumModesExt) ? '0 : up_ext[SelW-1:0];
        shown_d   = preview_d;
      end else if (step_d <= -limit_s) begin
        step_d    = '0;
        preview_d = (preview_q == '0) ? ModeMax : preview_q - SelW'(1);
        shown_d   = preview_d;
      end
      last_phase_d = phase;

      if (item_i.switch_level != last_rd_q) begin
        last_chg_d = item_i.now_ms;
      end
      elapsed = item_i.now_ms - last_chg_d;
      if (elapsed > {16'd0, cfg_i.debounce_ms} && item_i.switch_level != stable_q) begin
        stable_d = item_i.switch_level;
        if (item_i.switch_level == SwPressed) begin
          current_d = preview_d;
          shown_d   = preview_d;
          changed   = 1'b1;
        end
      end
      last_rd_d = item_i.switch_level;
    end
  end

  assign shown_ext = {1'b0, shown_d};

  always_comb begin
    res_o.changed      = changed;
    res_o.active_mode  = current_d[1:0];
    res_o.pending_mode = preview_d[1:0];
    if (shown_ext < LedCount) begin
      res_o.led_n = ~(4'b0001 << shown_d[1:0]);
    end else begin
      res_o.led_n = 4'hF;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_phase_q <= '0;
      primed_q     <= 1'b0;
      step_q       <= '0;
      preview_q    <= ModeRst;
      current_q    <= ModeRst;
      shown_q      <= ModeRst;
      last_rd_q    <= SwReleased;
      stable_q     <= SwReleased;
      last_chg_q   <= '0;
    end else if (fire_i) begin
      last_phase_q <= last_phase_d;
      primed_q     <= primed_d;
      step_q       <= step_d;
      preview_q    <= preview_d;
      current_q    <= current_d;
      shown_q      <= shown_d;
      last_rd_q    <= last_rd_d;
      stable_q     <= stable_d;
      last_chg_q   <= last_chg_d;
    end
  end

endmodule

/* design/rotary_mode_selector_top.sv */
// Rotary mode selector: a quadrature encoder with detent stepping and a
// debounced push switch that confirms the selected mode. Items enter an input
// register, pass through the combinational update logic of rms_core and land
// in a result register; the block accepts one item per clock cycle while the
// output is not stalled. The state update in rms_core, registered on each
// fire, is the loop that sets this rate. Configuration registers sit at
// byte 0 (debounce_ms) and byte 4 (counts_per_detent); the user must see that
// they are written only while the block is idle, which the block itself does
// not enforce. Depends on rms_pkg, rms_stream_if, rms_cfg_regs and rms_core.
module rotary_mode_selector_top #(
  parameter int unsigned NUM_MODES = rms_pkg::NumModesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  rms_item_if.sink     item_i,
  rms_res_if.source    res_o
);
  import rms_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q, in_vld_d;
  result_t res_q, res_d;
  logic    out_vld_q, out_vld_d;
  logic    advance;
  logic    fire;
  logic    take;

  rms_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The result register frees up when empty or when its item is taken.
  assign advance      = !out_vld_q || res_o.ready;
  assign fire         = in_vld_q && advance;
  assign item_i.ready = !in_vld_q || advance;
  assign take         = item_i.valid && item_i.ready;

  rms_core #(
    .NUM_MODES (NUM_MODES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_i.data;
    end
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = res_q;

endmodule

/* design/rms_checker.sv */
// Port-level checks for rotary_mode_selector_top, attached by a bind.
// Depends on rms_pkg for the payload types.
module rms_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input rms_pkg::result_t out_data_i
);
  import rms_pkg::*;

  logic in_take;
  logic out_stall;

  assign in_take   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // The LEDs are either all dark or light exactly one mode.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ($onehot(~out_data_i.led_n) || out_data_i.led_n == 4'hF))
    else $error("led_n is neither one-hot low nor all off");

  // A confirming press shows the confirmed mode on the LEDs, or leaves them all dark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_data_i.changed) |->
      (out_data_i.led_n == 4'hF ||
       out_data_i.led_n == ~(4'b0001 << out_data_i.active_mode)))
    else $error("confirmed mode is not the one shown");

  // A result only appears once an accepted item has passed the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_take, 2))
    else $error("result appeared without an accepted item");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> (out_valid_i && $stable(out_data_i)))
    else $error("stalled result changed");

endmodule

bind rotary_mode_selector_top rms_checker u_rms_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_data_i  (res_o.data)
);
